// File: rtl/core/u8icd_pkg.sv
// Types, constants and lead byte helpers for the UTF-8 indexed character decoder.
package u8icd_pkg;

  localparam int CODE_W = 31;

  typedef logic [7:0]        byte_t;
  typedef logic [CODE_W-1:0] code_t;
  typedef logic [2:0]        count_t;

  // Lead bytes at or above this value stop the scan
  localparam byte_t LEAD_STOP_MIN = 8'hFE;
  localparam byte_t ZERO_BYTE     = 8'h00;
  // Payload bits of a continuation byte
  localparam logic [5:0] CONT_MASK = 6'h3F;
  // Payload bits of a lead byte before the length shift
  localparam logic [6:0] LEAD_MASK = 7'h7F;

  // Count the leading ones of a byte (seven or more reads as seven)
  function automatic count_t lead_ones(input byte_t b);
    count_t n;
    case (b) inside
      8'b0???????: n = 3'd0;
      8'b10??????: n = 3'd1;
      8'b110?????: n = 3'd2;
      8'b1110????: n = 3'd3;
      8'b11110???: n = 3'd4;
      8'b111110??: n = 3'd5;
      8'b1111110?: n = 3'd6;
      default:     n = 3'd7;
    endcase
    return n;
  endfunction

endpackage

// File: rtl/core/utf8_indexed_char_decoder.sv
// UTF-8 indexed character decoder: picks one character of a byte string by index.
//
// Input channel (in_valid/in_ready): one byte of a string per word, with
// end_of_string on the final byte. char_index is taken from the first word of
// each string. Bytes are decoded leniently: the leading ones of a lead byte
// give the length, continuation bytes are not checked, a stray continuation
// lead gives its low six bits. A zero lead byte or a lead of 0xFE/0xFF stops
// the scan for the rest of the string.
// Output channel (out_valid/out_ready): one word per string, found and
// code_point, shown in the cycle after the end_of_string word is accepted.
// Throughput is one word per cycle: each byte is decoded by a single pass of
// shift, mask and count logic into the state registers. The output register
// only blocks an end_of_string word while a previous result is still held;
// other bytes keep flowing while the receiver stalls.
// Reset clears the output valid and puts the decoder at the start of a string.
module utf8_indexed_char_decoder #(
  parameter int INDEX_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  u8icd_pkg::byte_t      data_byte,
  input  logic                  end_of_string,
  input  logic [15:0]           char_index,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  found,
  output u8icd_pkg::code_t      code_point
);
  import u8icd_pkg::*;

  localparam int IDX_KEEP = (INDEX_WIDTH < 16) ? INDEX_WIDTH : 16;

  typedef logic [INDEX_WIDTH-1:0] idx_t;

  // Decoder state
  logic   at_start;
  idx_t   target_position;
  idx_t   chars_seen;
  count_t bytes_remaining;
  code_t  partial_value;
  logic   scan_stopped;
  logic   hit_flag;
  code_t  hit_value;

  // Next state
  idx_t   target_position_next;
  idx_t   chars_seen_next;
  count_t bytes_remaining_next;
  code_t  partial_value_next;
  logic   scan_stopped_next;
  logic   hit_flag_next;
  code_t  hit_value_next;

  // Working values
  idx_t   cur_seen;
  count_t cur_rem;
  code_t  cur_part;
  logic   cur_stop;
  logic   cur_hit;
  code_t  cur_hv;
  count_t lead_n;
  logic   fin;
  code_t  fin_val;
  logic   accept;

  assign accept   = in_valid && in_ready;
  // Hold an end word only while a previous result waits
  assign in_ready = !out_valid || out_ready || !end_of_string;

  // Decode one byte
  always_comb begin
    target_position_next = at_start ? idx_t'(char_index[IDX_KEEP-1:0]) : target_position;
    cur_seen = at_start ? '0   : chars_seen;
    cur_rem  = at_start ? '0   : bytes_remaining;
    cur_part = at_start ? '0   : partial_value;
    cur_stop = at_start ? 1'b0 : scan_stopped;
    cur_hit  = at_start ? 1'b0 : hit_flag;
    cur_hv   = at_start ? '0   : hit_value;

    chars_seen_next      = cur_seen;
    bytes_remaining_next = cur_rem;
    partial_value_next   = cur_part;
    scan_stopped_next    = cur_stop;
    hit_flag_next        = cur_hit;
    hit_value_next       = cur_hv;
    lead_n  = lead_ones(data_byte);
    fin     = 1'b0;
    fin_val = '0;

    if (!cur_stop) begin
      if (cur_rem != 3'd0) begin
        // Append a continuation group
        partial_value_next   = {cur_part[CODE_W-7:0], data_byte[5:0] & CONT_MASK};
        bytes_remaining_next = 3'(cur_rem - 3'd1);
        if (cur_rem == 3'd1) begin
          fin     = 1'b1;
          fin_val = {cur_part[CODE_W-7:0], data_byte[5:0] & CONT_MASK};
        end
      end else if (data_byte == ZERO_BYTE || data_byte >= LEAD_STOP_MIN) begin
        scan_stopped_next = 1'b1;
      end else if (lead_n == 3'd0) begin
        fin     = 1'b1;
        fin_val = code_t'(data_byte);
      end else if (lead_n == 3'd1) begin
        fin     = 1'b1;
        fin_val = code_t'(data_byte[5:0] & CONT_MASK);
      end else begin
        // Open a multi-byte character
        partial_value_next   = code_t'(data_byte[6:0] & (LEAD_MASK >> lead_n));
        bytes_remaining_next = 3'(lead_n - 3'd1);
      end
    end

    // Close a character: keep it on a hit, else advance the count
    if (fin) begin
      if (cur_seen == target_position_next) begin
        hit_flag_next     = 1'b1;
        hit_value_next    = fin_val;
        scan_stopped_next = 1'b1;
      end else begin
        chars_seen_next = cur_seen + idx_t'(1);
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      at_start        <= 1'b1;
      target_position <= '0;
      chars_seen      <= '0;
      bytes_remaining <= '0;
      partial_value   <= '0;
      scan_stopped    <= 1'b0;
      hit_flag        <= 1'b0;
      hit_value       <= '0;
    end else if (accept) begin
      at_start        <= end_of_string;
      target_position <= target_position_next;
      chars_seen      <= chars_seen_next;
      bytes_remaining <= bytes_remaining_next;
      partial_value   <= partial_value_next;
      scan_stopped    <= scan_stopped_next;
      hit_flag        <= hit_flag_next;
      hit_value       <= hit_value_next;
    end
  end

  // Output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && end_of_string) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (accept && end_of_string) begin
      found      <= hit_flag_next;
      code_point <= hit_flag_next ? hit_value_next : '0;
    end
  end

  // A result word always follows an accepted end word
  a_end_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept && end_of_string |=> out_valid)
    else $error("no result after end of string");

  // Code point is zero unless the character was found
  a_zero_when_missing: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> code_point == '0)
    else $error("code point set without a hit");

  // The character count never passes the target
  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    chars_seen <= target_position)
    else $error("character count passed the target");

  // A hit always stops the scan
  a_hit_stops: assert property (@(posedge clk) disable iff (rst)
    hit_flag |-> scan_stopped)
    else $error("hit without stopped scan");

  // At most five continuation bytes are ever pending
  a_rem_bounded: assert property (@(posedge clk) disable iff (rst)
    bytes_remaining <= 3'd5)
    else $error("continuation count out of range");

endmodule
